### sv/button_press_sequence_counter_macros.svh
// ----------------------------------------------------------------------------
// Button press sequence counter assertion macros
// Concurrent check templates shared by the verification checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_SEQUENCE_COUNTER_MACROS_SVH
`define BUTTON_PRESS_SEQUENCE_COUNTER_MACROS_SVH

// Implication checked on every edge outside reset.
`define BPSC_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpsc implication check failed");

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define BPSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpsc next-cycle check failed");

// Condition that must hold on the cycle after reset is applied.
`define BPSC_ASSERT_AFTER_RESET(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("bpsc post-reset check failed");

`endif

### sv/bpsc_pkg.sv
// ----------------------------------------------------------------------------
// Button press sequence counter package
// Widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 15;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0]    time_ms_t;
  typedef logic [CFG_W-1:0]     cfg_val_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes
  localparam cfg_idx_t REG_IDLE_LEVEL = 3'd0;
  localparam cfg_idx_t REG_SHORT_MS   = 3'd1;
  localparam cfg_idx_t REG_LONG_MS    = 3'd2;
  localparam cfg_idx_t REG_EXPIRE_MS  = 3'd3;
  localparam cfg_idx_t REG_TIMEOUT_MS = 3'd4;
  localparam cfg_idx_t REG_RESET_MS   = 3'd5;

  // Register reset values
  localparam logic     IDLE_LEVEL_RST = 1'b1;
  localparam cfg_val_t SHORT_MS_RST   = 15'd60;
  localparam cfg_val_t LONG_MS_RST    = 15'd1000;
  localparam cfg_val_t EXPIRE_MS_RST  = 15'd5000;
  localparam cfg_val_t TIMEOUT_MS_RST = 15'd3000;
  localparam cfg_val_t RESET_MS_RST   = 15'd3000;

endpackage

### sv/bpsc_poll_if.sv
// ----------------------------------------------------------------------------
// Button poll channel
// Valid/ready channel carrying one sample of the button pin and its timestamp.
// ----------------------------------------------------------------------------
interface bpsc_poll_if
  import bpsc_pkg::*;
;
  logic     valid;
  logic     ready;
  logic     pin_level;
  time_ms_t now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

### sv/bpsc_result_if.sv
// ----------------------------------------------------------------------------
// Button result channel
// Valid/ready channel carrying the press status and sequence counts per poll.
// ----------------------------------------------------------------------------
interface bpsc_result_if
  import bpsc_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   pressed;
  logic   edge_res;
  logic   released;
  logic   held_short;
  logic   held_long;
  logic   sequence_ready;
  logic   sequence_ongoing;
  count_t short_count;
  count_t long_count;

  modport source (
    output valid, output pressed, output edge_res, output released,
    output held_short, output held_long, output sequence_ready,
    output sequence_ongoing, output short_count, output long_count,
    input ready
  );
  modport sink (
    input valid, input pressed, input edge_res, input released,
    input held_short, input held_long, input sequence_ready,
    input sequence_ongoing, input short_count, input long_count,
    output ready
  );
endinterface

### sv/bpsc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface bpsc_cfg_if
  import bpsc_pkg::*;
;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cfg_val_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/button_press_sequence_counter.sv
// ----------------------------------------------------------------------------
// Button press sequence counter
// Short/long press detector with sequence timeout, expiry and hold reset.
// ----------------------------------------------------------------------------
// Takes one poll per clock cycle while poll.ready is high. Each poll lands in
// an input register; one pass of logic (two 32-bit timestamp subtractions and
// their compares against the configured limits) then updates the sequence
// state and loads the result register, once that register is empty or its
// result is being taken. Polls keep flowing while a result waits to be taken;
// poll.ready drops only when both registers are full and the result is stalled.
// Configuration writes are taken at any time (cfg.ready is always high) and
// must only be issued while no poll is in flight; out-of-range indexes are
// ignored.
module button_press_sequence_counter
  import bpsc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  bpsc_poll_if.sink       poll,
  bpsc_cfg_if.sink        cfg,
  bpsc_result_if.source   result
);

  // Configuration registers
  logic     idle_level;
  cfg_val_t short_ms;
  cfg_val_t long_ms;
  cfg_val_t expire_ms;
  cfg_val_t timeout_ms;
  cfg_val_t reset_ms;

  // Input register
  logic     s1_valid;
  logic     s1_pin;
  time_ms_t s1_now;

  // Sequence state
  logic     pressed_now;
  logic     closed_flag;
  logic     short_seen;
  logic     long_seen;
  time_ms_t time_of_edge;
  time_ms_t time_of_mark;
  count_t   short_tally;
  count_t   long_tally;

  // Next values
  logic     pressed_next;
  logic     edge_next;
  logic     closed_next;
  logic     short_seen_next;
  logic     long_seen_next;
  time_ms_t time_of_edge_next;
  time_ms_t time_of_mark_next;
  count_t   short_tally_next;
  count_t   long_tally_next;
  logic     held_short_next;
  logic     held_long_next;

  // Intermediate terms
  time_ms_t since_mark;
  time_ms_t since_edge;
  logic     start_press;
  logic     holding;
  logic     short_fire;
  logic     long_aged;
  logic     long_fire;
  logic     reset_aged;
  logic     reset_fire;
  logic     idle_seq;
  logic     closed_mid;
  logic     expire_fire;
  count_t   short_step;
  count_t   long_step;

  logic     poll_take;
  logic     s2_load;

  assign s2_load   = s1_valid && (!result.valid || result.ready);
  assign poll.ready = !s1_valid || s2_load;
  assign poll_take = poll.valid && poll.ready;
  assign cfg.ready = 1'b1;

  always_comb begin
    pressed_next = (s1_pin != idle_level);
    edge_next    = (pressed_next != pressed_now);
    since_mark   = s1_now - time_of_mark;

    start_press = !closed_flag && edge_next && !pressed_now;
    holding     = !closed_flag && !edge_next && pressed_next;

    short_fire = holding && !short_seen &&
                 (since_mark >= {{(TIME_W-CFG_W){1'b0}}, short_ms});
    // A short press restarts the mark at now, so the long test sees zero age
    long_aged  = short_fire ? (long_ms == '0)
                            : (since_mark >= {{(TIME_W-CFG_W){1'b0}}, long_ms});
    long_fire  = holding && !long_seen && long_aged;
    reset_aged = (short_fire || long_fire)
                 ? (reset_ms == '0)
                 : (since_mark >= {{(TIME_W-CFG_W){1'b0}}, reset_ms});

    short_seen_next = start_press ? 1'b0 : (short_seen || short_fire);
    long_seen_next  = start_press ? 1'b0 : (long_seen || long_fire);
    reset_fire      = holding && long_seen_next && reset_aged;

    time_of_mark_next = (start_press || short_fire || long_fire) ? s1_now
                                                                 : time_of_mark;

    short_step = short_tally + {{(COUNT_W-1){1'b0}}, short_fire}
                             - {{(COUNT_W-1){1'b0}}, long_fire};
    long_step  = long_tally + {{(COUNT_W-1){1'b0}}, long_fire};

    // Released with a sequence in progress: mark is untouched on this path
    idle_seq    = !pressed_next && (short_seen_next || long_seen_next);
    closed_mid  = closed_flag ||
                  (idle_seq && (since_mark >= {{(TIME_W-CFG_W){1'b0}}, timeout_ms}));
    expire_fire = idle_seq && closed_mid &&
                  (since_mark >= {{(TIME_W-CFG_W){1'b0}}, expire_ms});
    closed_next = closed_mid && !expire_fire;

    if (reset_fire || expire_fire) begin
      short_tally_next = '0;
      long_tally_next  = '0;
    end else begin
      short_tally_next = short_step;
      long_tally_next  = long_step;
    end

    time_of_edge_next = edge_next ? s1_now : time_of_edge;
    since_edge        = s1_now - time_of_edge;
    held_short_next = pressed_next &&
                      (edge_next ? (short_ms == '0)
                                 : (since_edge >= {{(TIME_W-CFG_W){1'b0}}, short_ms}));
    held_long_next  = pressed_next &&
                      (edge_next ? (long_ms == '0)
                                 : (since_edge >= {{(TIME_W-CFG_W){1'b0}}, long_ms}));
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_level <= IDLE_LEVEL_RST;
      short_ms   <= SHORT_MS_RST;
      long_ms    <= LONG_MS_RST;
      expire_ms  <= EXPIRE_MS_RST;
      timeout_ms <= TIMEOUT_MS_RST;
      reset_ms   <= RESET_MS_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_IDLE_LEVEL: idle_level <= cfg.data[0];
        REG_SHORT_MS:   short_ms   <= cfg.data;
        REG_LONG_MS:    long_ms    <= cfg.data;
        REG_EXPIRE_MS:  expire_ms  <= cfg.data;
        REG_TIMEOUT_MS: timeout_ms <= cfg.data;
        REG_RESET_MS:   reset_ms   <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (poll_take) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_take) begin
      s1_pin <= poll.pin_level;
      s1_now <= poll.now_ms;
    end
  end

  // Sequence state, advanced once per poll
  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_now  <= 1'b0;
      closed_flag  <= 1'b0;
      short_seen   <= 1'b0;
      long_seen    <= 1'b0;
      time_of_edge <= '0;
      time_of_mark <= '0;
      short_tally  <= '0;
      long_tally   <= '0;
    end else if (s2_load) begin
      pressed_now  <= pressed_next;
      closed_flag  <= closed_next;
      short_seen   <= short_seen_next;
      long_seen    <= long_seen_next;
      time_of_edge <= time_of_edge_next;
      time_of_mark <= time_of_mark_next;
      short_tally  <= short_tally_next;
      long_tally   <= long_tally_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s2_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      result.pressed          <= pressed_next;
      result.edge_res         <= edge_next;
      result.released         <= edge_next && !pressed_next;
      result.held_short       <= held_short_next;
      result.held_long        <= held_long_next;
      result.sequence_ready   <= closed_next;
      result.sequence_ongoing <= (short_tally_next != '0) || (long_tally_next != '0);
      result.short_count      <= short_tally_next;
      result.long_count       <= long_tally_next;
    end
  end

endmodule

### sv/bpsc_checker.sv
// ----------------------------------------------------------------------------
// Button press sequence counter checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_press_sequence_counter_macros.svh"

module bpsc_checker
  import bpsc_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   poll_ready,
  input logic   res_valid,
  input logic   res_ready,
  input logic   pressed,
  input logic   edge_res,
  input logic   released,
  input logic   sequence_ongoing,
  input count_t short_count,
  input count_t long_count
);

  // A stalled result holds its counts
  `BPSC_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable(short_count) && $stable(long_count) && $stable(pressed))

  // A release is always an edge to the unpressed state
  `BPSC_ASSERT_IMPLY(a_release_edge, res_valid && released, edge_res && !pressed)

  // Ongoing flag tracks the live tallies
  `BPSC_ASSERT_IMPLY(a_ongoing_counts, res_valid, sequence_ongoing == ((short_count != '0) || (long_count != '0)))

  // Reset empties both registers
  `BPSC_ASSERT_AFTER_RESET(a_reset_empty, !res_valid && poll_ready)

endmodule

bind button_press_sequence_counter bpsc_checker u_bpsc_checker (
  .clk              (clk),
  .rst              (rst),
  .poll_ready       (poll.ready),
  .res_valid        (result.valid),
  .res_ready        (result.ready),
  .pressed          (result.pressed),
  .edge_res         (result.edge_res),
  .released         (result.released),
  .sequence_ongoing (result.sequence_ongoing),
  .short_count      (result.short_count),
  .long_count       (result.long_count)
);
